FILE: rtl/repeating_timer_queue_assert.svh
// Assertion macros used by the timer queue port checker.
`ifndef REPEATING_TIMER_QUEUE_ASSERT_SVH
`define REPEATING_TIMER_QUEUE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define RTQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequence is checked in the cycle after the antecedent.
`define RTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/rtq_pkg.sv
// Package with the types and constants of the repeating timer queue.
`default_nettype none
package rtq_pkg;
  localparam int unsigned RtqSlots = 16;
  localparam int unsigned TimeW = 48;
  localparam int unsigned IvalW = 24;
  localparam int unsigned IdW = 16;
  localparam int unsigned CntW = 16;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_TICK = 2'd3;

  localparam logic [1:0] KIND_FIRED = 2'd0;
  localparam logic [1:0] KIND_ADD = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_DONE = 2'd3;

  localparam logic [1:0] ERR_OK = 2'd0;
  localparam logic [1:0] ERR_COUNT = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN = 2'd2;
  localparam logic [1:0] ERR_FULL = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN_RD, ST_SCAN, ST_ADD, ST_REM, ST_RST, ST_PICK, ST_FIRE_RD,
    ST_FIRE, ST_OUT
  } rtq_state_t;
endpackage
`default_nettype wire

FILE: rtl/rtq_if.sv
// Valid/ready channel interfaces of the timer queue.
`default_nettype none
interface rtq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [23:0] interval_ms;
  logic signed [15:0] repeat_count;
  logic [15:0] timer_id;
  modport source (output valid, command, interval_ms, repeat_count, timer_id, input ready);
  modport sink (input valid, command, interval_ms, repeat_count, timer_id, output ready);
endinterface

interface rtq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [15:0] result_id;
  logic [1:0]  error_code;
  logic        last_result;
  modport source (output valid, result_kind, result_id, error_code, last_result, input ready);
  modport sink (input valid, result_kind, result_id, error_code, last_result, output ready);
endinterface
`default_nettype wire

FILE: rtl/repeating_timer_queue.sv
// Top level of the repeating timer queue: slot memory and command sequencer.
//
//  channel | direction | payload
//  in_     | sink      | command, interval_ms, repeat_count, timer_id
//  out_    | source    | result_kind, result_id, error_code, last_result
//
// Each sweep reads one slot a cycle, starting from ST_SCAN_RD, which issues the first read.
// Add, remove and restart run one sweep, their action state and ST_OUT per input transfer.
// A tick runs one sweep and ST_PICK, then ST_FIRE_RD, ST_FIRE and ST_OUT for each timer that fires,
// because every firing is followed by a fresh sweep to choose the next timer.
// A stalled result holds the sequencer until its transfer.
// Reset is synchronous and clears the valid bits, time, id counter and control.
`default_nettype none
module repeating_timer_queue
  import rtq_pkg::*;
#(
  parameter int unsigned TIMER_SLOTS = RtqSlots
) (
  input wire logic clk,
  input wire logic rst_n,
  rtq_in_if.sink   in_ch,
  rtq_out_if.source out_ch
);
  localparam int unsigned SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned MW = TimeW + IdW + IvalW + CntW;

  // Slot memory: due time, id, interval and count in one word.
  logic [MW-1:0] mem [TIMER_SLOTS];
  logic [MW-1:0] rd_r;
  logic          we;
  logic [SW-1:0] wa, ra;
  logic [MW-1:0] wd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra];
  end

  logic [TimeW-1:0] rd_due;
  logic [IdW-1:0]   rd_id;
  logic [IvalW-1:0] rd_ival;
  logic [CntW-1:0]  rd_cnt;
  assign {rd_due, rd_id, rd_ival, rd_cnt} = rd_r;

  rtq_state_t state_r, state_nxt;
  logic [TIMER_SLOTS-1:0] valid_r, valid_nxt, pend_r, pend_nxt;
  logic [TimeW-1:0] now_r, now_nxt;
  logic [IdW-1:0]   nid_r, nid_nxt;
  logic [SW:0]      idx_r, idx_nxt;      // sweep counter, one bit wider
  logic [SW-1:0]    sidx_r, sidx_nxt;    // index of the slot being read
  logic [1:0]       cmd_r, cmd_nxt;
  logic [IvalW-1:0] ival_r, ival_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [IdW-1:0]   tid_r, tid_nxt;
  logic             hit_r, hit_nxt, any_r, any_nxt;
  logic [SW-1:0]    hslot_r, hslot_nxt;
  logic [TimeW-1:0] bdue_r, bdue_nxt;
  logic [IdW-1:0]   bid_r, bid_nxt;
  logic [1:0]       okind_r, okind_nxt, oerr_r, oerr_nxt;
  logic [IdW-1:0]   oid_r, oid_nxt;
  logic             olast_r, olast_nxt, ovalid_r, ovalid_nxt;
  logic             last_rd;

  // The sweep ends once the last slot's word is in the read register.
  assign last_rd = (idx_r == (SW+1)'(TIMER_SLOTS));

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_ch.valid) state_nxt = ST_SCAN_RD;
      ST_SCAN_RD: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (last_rd) begin
          unique case (cmd_r)
            CMD_ADD:     state_nxt = ST_ADD;
            CMD_REMOVE:  state_nxt = ST_REM;
            CMD_RESTART: state_nxt = ST_RST;
            default:     state_nxt = ST_PICK;
          endcase
        end
      end
      ST_ADD, ST_REM, ST_RST: state_nxt = ST_OUT;
      ST_PICK:    state_nxt = any_r ? ST_FIRE_RD : ST_OUT;
      ST_FIRE_RD: state_nxt = ST_FIRE;
      ST_FIRE:    state_nxt = ST_OUT;
      ST_OUT: begin
        if (!ovalid_r || out_ch.ready)
          state_nxt = (cmd_r == CMD_TICK && !olast_r) ? ST_SCAN_RD : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and output logic.
  always_comb begin
    logic [SW-1:0] slot;
    logic [CntW-1:0] c2;
    slot = idx_r[SW-1:0];
    c2 = rd_cnt;
    valid_nxt = valid_r; pend_nxt = pend_r; now_nxt = now_r; nid_nxt = nid_r;
    idx_nxt = idx_r; sidx_nxt = sidx_r; cmd_nxt = cmd_r; ival_nxt = ival_r;
    cnt_nxt = cnt_r; tid_nxt = tid_r; hit_nxt = hit_r; any_nxt = any_r;
    hslot_nxt = hslot_r; bdue_nxt = bdue_r; bid_nxt = bid_r;
    okind_nxt = okind_r; oerr_nxt = oerr_r; oid_nxt = oid_r; olast_nxt = olast_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    we = 1'b0; wa = sidx_r; wd = rd_r; ra = slot;
    in_ch.ready = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0; sidx_nxt = '0; hit_nxt = 1'b0; any_nxt = 1'b0;
        cmd_nxt = in_ch.command; ival_nxt = in_ch.interval_ms;
        cnt_nxt = in_ch.repeat_count; tid_nxt = in_ch.timer_id;
        ra = '0;
        if (in_ch.valid && in_ch.command == CMD_TICK) begin
          now_nxt = now_r + TimeW'(1);
          pend_nxt = '0;
        end
        if (in_ch.valid && in_ch.command == CMD_ADD) begin
          // Free slot search over the valid bits.
          for (int i = TIMER_SLOTS - 1; i >= 0; i--)
            if (!valid_r[i]) begin hit_nxt = 1'b1; hslot_nxt = SW'(i); end
        end
      end
      ST_SCAN_RD: begin
        idx_nxt = idx_r + 1'b1; sidx_nxt = slot; any_nxt = 1'b0;
      end
      ST_SCAN: begin
        // rd_r holds slot sidx_r.
        unique case (cmd_r)
          CMD_REMOVE: begin
            if (valid_r[sidx_r] && rd_id == tid_r && !hit_r) begin
              hit_nxt = 1'b1; hslot_nxt = sidx_r;
            end
          end
          CMD_RESTART: begin
            if (valid_r[sidx_r]) begin
              we = 1'b1; wd = {now_r + TimeW'(rd_ival), rd_id, rd_ival, rd_cnt};
            end
          end
          CMD_TICK: begin
            // First sweep marks due slots, later sweeps only pick.
            if (!hit_r && valid_r[sidx_r] && rd_due <= now_r)
              pend_nxt[sidx_r] = 1'b1;
            if ((pend_r[sidx_r] || (!hit_r && valid_r[sidx_r] && rd_due <= now_r)) &&
                (!any_r || rd_due < bdue_r || (rd_due == bdue_r && rd_id < bid_r))) begin
              any_nxt = 1'b1; bdue_nxt = rd_due; bid_nxt = rd_id; hslot_nxt = sidx_r;
            end
          end
          default: ;
        endcase
        sidx_nxt = slot;
        if (!last_rd) idx_nxt = idx_r + 1'b1;
        if (last_rd && cmd_r == CMD_TICK) hit_nxt = 1'b1;
      end
      ST_ADD: begin
        okind_nxt = KIND_ADD; olast_nxt = 1'b1; ovalid_nxt = 1'b1; oid_nxt = '0;
        if (cnt_r == '0) oerr_nxt = ERR_COUNT;
        else if (!hit_r) oerr_nxt = ERR_FULL;
        else begin
          oerr_nxt = ERR_OK; nid_nxt = nid_r + 1'b1; oid_nxt = nid_r + 1'b1;
          valid_nxt[hslot_r] = 1'b1;
          we = 1'b1; wa = hslot_r;
          wd = {now_r + TimeW'(ival_r), nid_r + IdW'(1), ival_r, cnt_r};
        end
      end
      ST_REM: begin
        okind_nxt = KIND_REMOVE; olast_nxt = 1'b1; ovalid_nxt = 1'b1; oid_nxt = '0;
        oerr_nxt = hit_r ? ERR_OK : ERR_UNKNOWN;
        if (hit_r) valid_nxt[hslot_r] = 1'b0;
      end
      ST_RST: begin
        okind_nxt = KIND_DONE; olast_nxt = 1'b1; ovalid_nxt = 1'b1;
        oid_nxt = '0; oerr_nxt = ERR_OK;
      end
      ST_PICK: begin
        ra = hslot_r;
        if (!any_r) begin
          okind_nxt = KIND_DONE; olast_nxt = 1'b1; ovalid_nxt = 1'b1;
          oid_nxt = '0; oerr_nxt = ERR_OK;
        end
      end
      ST_FIRE_RD: ra = hslot_r;
      ST_FIRE: begin
        // Fire the chosen slot and update it.
        okind_nxt = KIND_FIRED; olast_nxt = 1'b0; ovalid_nxt = 1'b1;
        oid_nxt = rd_id; oerr_nxt = ERR_OK;
        pend_nxt[hslot_r] = 1'b0;
        if (rd_cnt != '0 && !rd_cnt[CntW-1]) c2 = rd_cnt - 1'b1;
        we = 1'b1; wa = hslot_r;
        if (c2 == '0) valid_nxt[hslot_r] = 1'b0;
        wd = {rd_due + TimeW'(rd_ival), rd_id, rd_ival, c2};
      end
      ST_OUT: begin
        idx_nxt = '0; ra = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; valid_r <= '0; pend_r <= '0; now_r <= '0; nid_r <= '0;
      ovalid_r <= 1'b0; idx_r <= '0; hit_r <= 1'b0; any_r <= 1'b0;
    end else begin
      state_r <= state_nxt; valid_r <= valid_nxt; pend_r <= pend_nxt;
      now_r <= now_nxt; nid_r <= nid_nxt; ovalid_r <= ovalid_nxt;
      idx_r <= idx_nxt; hit_r <= hit_nxt; any_r <= any_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sidx_r <= sidx_nxt; cmd_r <= cmd_nxt; ival_r <= ival_nxt; cnt_r <= cnt_nxt;
    tid_r <= tid_nxt; hslot_r <= hslot_nxt; bdue_r <= bdue_nxt; bid_r <= bid_nxt;
    okind_r <= okind_nxt; oerr_r <= oerr_nxt; oid_r <= oid_nxt; olast_r <= olast_nxt;
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.result_kind = okind_r;
  assign out_ch.result_id = oid_r;
  assign out_ch.error_code = oerr_r;
  assign out_ch.last_result = olast_r;
endmodule
`default_nettype wire

FILE: rtl/rtq_checker.sv
// Port checker for the repeating timer queue, bound to the top level.
`default_nettype none
`include "repeating_timer_queue_assert.svh"
module rtq_checker
  import rtq_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [1:0] out_kind,
  input wire logic [1:0] out_err,
  input wire logic [15:0] out_id,
  input wire logic out_last
);
  // A stalled result holds.
  `RTQ_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_id), "result dropped")
  // Fired results are never last; others always are.
  `RTQ_ASSERT_IMP(a_last, out_valid, out_last == (out_kind != KIND_FIRED), "bad last flag")
  // Only add carries an id among non-fired results.
  `RTQ_ASSERT_IMP(a_id, out_valid && (out_kind == KIND_REMOVE || out_kind == KIND_DONE),
    out_id == 16'd0, "stray id")
  // Firings and tick or restart completions never carry an error.
  `RTQ_ASSERT_IMP(a_err, out_valid && (out_kind == KIND_FIRED || out_kind == KIND_DONE),
    out_err == ERR_OK, "stray error code")
  // No input is taken while a result waits.
  `RTQ_ASSERT_IMP(a_busy, out_valid, !in_ready, "input taken while busy")
endmodule

bind repeating_timer_queue rtq_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_kind(out_ch.result_kind),
  .out_err(out_ch.error_code), .out_id(out_ch.result_id), .out_last(out_ch.last_result)
);
`default_nettype wire

FILE: test/rtq_checker.sv
// Checker for the repeating timer queue: watches both channels, predicts and compares.
`timescale 1ns / 1ps
`default_nettype none
module rtq_scoreboard
  import rtq_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  rtq_in_if.sink   in_ch,
  rtq_out_if.sink  out_ch,
  output int       fail_count,
  output int       pending_results
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] id;
    logic [1:0]  err;
    logic        last;
  } timer_result_t;

  // Timer table as the block should hold it.
  logic [47:0] now_ms;
  logic [15:0] last_id;
  logic        live [RtqSlots];
  logic [15:0] tmr_id [RtqSlots];
  logic [47:0] tmr_due [RtqSlots];
  logic [23:0] tmr_ival [RtqSlots];
  logic [15:0] tmr_left [RtqSlots];

  timer_result_t result_q[$];

  function automatic timer_result_t mk(logic [1:0] k, logic [15:0] i, logic [1:0] e,
                                       logic l);
    timer_result_t r;
    r.kind = k;
    r.id = i;
    r.err = e;
    r.last = l;
    return r;
  endfunction

  // Add one expected result at the tail of the queue.
  function automatic void queue_result(timer_result_t r);
    result_q.insert(result_q.size(), r);
  endfunction

  // Apply one command to the table and queue the results it should give.
  task automatic apply_command(logic [1:0] cmd, logic [23:0] ival, logic [15:0] cnt,
                               logic [15:0] tid);
    int  free_slot;
    int  best;
    bit  due_now [RtqSlots];
    bit  done;
    free_slot = -1;
    done = 0;
    case (cmd)
      CMD_ADD: begin
        if (cnt == 16'd0) begin
          queue_result(mk(KIND_ADD, 16'd0, ERR_COUNT, 1'b1));
        end else begin
          for (int i = 0; i < RtqSlots; i++)
            if (!live[i] && free_slot < 0) free_slot = i;
          if (free_slot < 0) begin
            queue_result(mk(KIND_ADD, 16'd0, ERR_FULL, 1'b1));
          end else begin
            last_id = last_id + 16'd1;
            live[free_slot] = 1'b1;
            tmr_id[free_slot] = last_id;
            tmr_due[free_slot] = now_ms + 48'(ival);
            tmr_ival[free_slot] = ival;
            tmr_left[free_slot] = cnt;
            queue_result(mk(KIND_ADD, last_id, ERR_OK, 1'b1));
          end
        end
      end
      CMD_REMOVE: begin
        for (int i = 0; i < RtqSlots; i++)
          if (!done && live[i] && tmr_id[i] == tid) begin
            live[i] = 1'b0;
            done = 1;
          end
        queue_result(mk(KIND_REMOVE, 16'd0, done ? ERR_OK : ERR_UNKNOWN, 1'b1));
      end
      CMD_RESTART: begin
        for (int i = 0; i < RtqSlots; i++)
          if (live[i]) tmr_due[i] = now_ms + 48'(tmr_ival[i]);
        queue_result(mk(KIND_DONE, 16'd0, ERR_OK, 1'b1));
      end
      default: begin
        now_ms = now_ms + 48'd1;
        for (int i = 0; i < RtqSlots; i++) due_now[i] = live[i] && tmr_due[i] <= now_ms;
        // Each due timer fires once, earliest due time first, then lower id.
        forever begin
          best = -1;
          for (int i = 0; i < RtqSlots; i++)
            if (due_now[i] && (best < 0 || tmr_due[i] < tmr_due[best] ||
                (tmr_due[i] == tmr_due[best] && tmr_id[i] < tmr_id[best])))
              best = i;
          if (best < 0) break;
          due_now[best] = 0;
          queue_result(mk(KIND_FIRED, tmr_id[best], ERR_OK, 1'b0));
          if (tmr_left[best] != 16'd0 && !tmr_left[best][15])
            tmr_left[best] = tmr_left[best] - 16'd1;
          if (tmr_left[best] == 16'd0) live[best] = 1'b0;
          else tmr_due[best] = tmr_due[best] + 48'(tmr_ival[best]);
        end
        queue_result(mk(KIND_DONE, 16'd0, ERR_OK, 1'b1));
      end
    endcase
  endtask

  // Watch both channels at each edge.
  always @(posedge clk) begin
    timer_result_t seen;
    timer_result_t want;
    if (!rst_n) begin
      now_ms = 48'd0;
      last_id = 16'd0;
      for (int i = 0; i < RtqSlots; i++) live[i] = 1'b0;
      result_q.delete();
      fail_count <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen = mk(out_ch.result_kind, out_ch.result_id, out_ch.error_code,
                  out_ch.last_result);
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result transfer, actual %h", $time, seen);
          fail_count <= fail_count + 1;
        end else begin
          want = result_q.pop_front();
          if (seen !== want) begin
            $display("%0t: result mismatch, expected kind %0d id %0d err %0d last %0b,",
                     $time, want.kind, want.id, want.err, want.last);
            $display("    actual kind %0d id %0d err %0d last %0b",
                     seen.kind, seen.id, seen.err, seen.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        apply_command(in_ch.command, in_ch.interval_ms, in_ch.repeat_count,
                      in_ch.timer_id);
    end
    pending_results = result_q.size();
  end

endmodule
`default_nettype wire

FILE: test/testbench.sv
// Top of the timer queue testbench: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps
`default_nettype none
module testbench
  import rtq_pkg::*;
();

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_results;
  bit   no_idle;
  int   stall_left;

  rtq_in_if  in_ch ();
  rtq_out_if out_ch ();

  repeating_timer_queue uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  rtq_scoreboard chk (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                      .fail_count(fail_count), .pending_results(pending_results));

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit: far beyond the slowest legal run.
  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: ready drops in random bursts until the final part of the run.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= (stall_left == 1);
    end else if (!no_idle && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 15);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Present one command and hold it until the transfer, with an optional gap first.
  // Valid stays high after the transfer; the caller drops it before any wait.
  task automatic send_command(logic [1:0] cmd, logic [23:0] ival, logic [15:0] cnt,
                              logic [15:0] tid);
    int gap;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.interval_ms <= ival;
    in_ch.repeat_count <= cnt;
    in_ch.timer_id <= tid;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_random;
    int pick;
    logic [23:0] ival;
    logic [15:0] cnt;
    pick = $urandom_range(0, 99);
    ival = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 6));
    case ($urandom_range(0, 3))
      0: cnt = 16'($urandom);
      1: cnt = 16'hFFFF - 16'($urandom_range(0, 3));
      default: cnt = 16'($urandom_range(0, 4));
    endcase
    if (pick < 30) send_command(CMD_ADD, ival, cnt, 16'($urandom));
    else if (pick < 45)
      send_command(CMD_REMOVE, 24'($urandom), 16'($urandom),
                   ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                              : 16'($urandom_range(0, 60)));
    else if (pick < 50) send_command(CMD_RESTART, 24'($urandom), 16'($urandom), 16'($urandom));
    else send_command(CMD_TICK, 24'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    no_idle = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_TICK;
    in_ch.interval_ms = '0;
    in_ch.repeat_count = '0;
    in_ch.timer_id = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero count, unknown id, zero interval, extremes, full table, ties.
    send_command(CMD_ADD, 24'd5, 16'd0, 16'd0);
    send_command(CMD_REMOVE, 24'd0, 16'd0, 16'hFFFF);
    send_command(CMD_ADD, 24'd0, 16'd3, 16'd0);
    send_command(CMD_ADD, 24'hFFFFFF, 16'h8000, 16'd0);
    send_command(CMD_ADD, 24'd1, 16'h7FFF, 16'd0);
    send_command(CMD_ADD, 24'd1, 16'hFFFF, 16'd0);
    send_command(CMD_ADD, 24'd2, 16'd1, 16'd0);
    send_command(CMD_TICK, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
    send_command(CMD_TICK, 24'd0, 16'd0, 16'd0);
    send_command(CMD_RESTART, 24'd0, 16'd0, 16'd0);
    send_command(CMD_REMOVE, 24'd0, 16'd0, 16'd2);
    for (int i = 0; i < 14; i++) send_command(CMD_ADD, 24'd3, 16'd2, 16'd0);
    send_command(CMD_ADD, 24'd3, 16'd2, 16'd0);
    send_command(CMD_TICK, 24'd0, 16'd0, 16'd0);
    send_command(CMD_TICK, 24'd0, 16'd0, 16'd0);
    send_command(CMD_TICK, 24'd0, 16'd0, 16'd0);

    // Hold off until every expected result is in.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);

    // Clear the table fully so the random part starts from empty.
    for (int i = 0; i < 24; i++) send_command(CMD_REMOVE, 24'd0, 16'd0, 16'(i));

    for (int n = 0; n < 360; n++) begin
      if (n == 300) no_idle = 1;
      send_random();
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
+incdir+rtl
rtl/rtq_pkg.sv
rtl/rtq_if.sv
rtl/repeating_timer_queue.sv
rtl/rtq_checker.sv
test/rtq_checker.sv
test/testbench.sv
